>>> src/stw_pkg.sv
// Types and codes shared by the structure table walker.
`default_nettype none

package stw_pkg;

	localparam logic [7:0]  END_OF_TABLE_TYPE = 8'd127;
	localparam logic [7:0]  HEADER_BYTES      = 8'd4;
	localparam logic [31:0] MAX_TABLE_RESET   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_HEADER    = 2'd1,
		PH_FORMATTED = 2'd2,
		PH_STRINGS   = 2'd3
	} stw_phase_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_END       = 2'd1,
		ST_TOO_BIG   = 2'd2,
		ST_MALFORMED = 2'd3
	} stw_status_t;

	// Header byte offsets within a structure.
	localparam logic [1:0] HB_TYPE      = 2'd0;
	localparam logic [1:0] HB_LENGTH    = 2'd1;
	localparam logic [1:0] HB_HANDLE_LO = 2'd2;
	localparam logic [1:0] HB_HANDLE_HI = 2'd3;

	typedef struct packed {
		logic [7:0] table_byte;
		logic       table_start;
	} stw_in_t;

	typedef struct packed {
		logic [7:0]  struct_type;
		logic [15:0] struct_handle;
		logic [31:0] struct_length;
		logic [15:0] struct_count;
		logic [31:0] table_length;
		stw_status_t walk_status;
	} stw_out_t;

endpackage

`default_nettype wire

>>> src/smbios_table_walker.sv
// Structure table walker: byte-serial parse of a structure table with per-structure reports.
//
// Usage:
//   in_data carries one table byte per word plus a start flag; a word is taken on
//   in_valid & in_ready. A start flag clears the counts and treats its byte as the
//   type byte of the first structure. Each structure is reported on out_data when
//   its string set ends (two zero bytes in a row), at its type byte if end of table, or at
//   a malformed length byte, with status done, end of table, exceeds maximum or malformed.
//   After an end, an error or a malformed header the block drops bytes until the next start.
//   cfg_wr_en / cfg_wr_data write the maximum table length; write only when idle.
// Latency and throughput:
//   One byte per cycle while in_ready is high. A result is registered at the edge that
//   takes the closing byte, in the output register or, on a stall, in the skid; the
//   per-byte update is one pass of incrementer, 32-bit add and compare.
// Stall:
//   A two-entry output buffer (output register plus skid) lets the block keep
//   taking bytes while a result waits; in_ready drops only when the skid is full.
// Reset:
//   arst_n clears the walk to idle, the counts to zero, the maximum to all ones
//   and empties the output buffer.
`default_nettype none

module smbios_table_walker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire stw_pkg::stw_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output stw_pkg::stw_out_t     out_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [31:0]      cfg_wr_data
);

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] a);
		return (&a) ? a : a + 16'd1;
	endfunction

	// walk state
	stw_pkg::stw_phase_t phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [7:0]  flen_q, flen_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] handle_q, handle_d;
	logic        pz_q, pz_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] tlen_q, tlen_d;
	logic [31:0] max_q;

	// output buffer
	logic              out_v_q;
	stw_pkg::stw_out_t out_q;
	logic              skid_v_q;
	stw_pkg::stw_out_t skid_q;

	logic              accept;
	logic              res_v;
	stw_pkg::stw_out_t res;

	stw_pkg::stw_phase_t eff_phase;
	logic [31:0] eff_pos;
	logic [15:0] eff_cnt;
	logic [31:0] eff_tlen;
	logic [7:0]  b;
	logic [1:0]  hpos;
	logic [31:0] pos_inc;
	logic [31:0] len_sum;
	logic        is_eot, is_malf, fmt_done, str_end, too_big;

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.table_byte;

	// A start restarts the walk at the type byte with cleared totals.
	assign eff_phase = in_data.table_start ? stw_pkg::PH_HEADER : phase_q;
	assign eff_pos   = in_data.table_start ? 32'd0 : pos_q;
	assign eff_cnt   = in_data.table_start ? 16'd0 : cnt_q;
	assign eff_tlen  = in_data.table_start ? 32'd0 : tlen_q;
	assign hpos      = eff_pos[1:0];

	assign pos_inc  = (&pos_q) ? pos_q : pos_q + 32'd1;
	assign len_sum  = sat_add32(tlen_q, pos_inc);

	assign is_eot   = (eff_phase == stw_pkg::PH_HEADER) && (hpos == stw_pkg::HB_TYPE)
			&& (b == stw_pkg::END_OF_TABLE_TYPE);
	assign is_malf  = (eff_phase == stw_pkg::PH_HEADER) && (hpos == stw_pkg::HB_LENGTH)
			&& (b < stw_pkg::HEADER_BYTES);
	assign fmt_done = (eff_phase == stw_pkg::PH_FORMATTED) && (pos_inc >= {24'd0, flen_q});
	assign str_end  = (eff_phase == stw_pkg::PH_STRINGS) && (b == 8'd0) && pz_q;
	assign too_big  = str_end && (len_sum > max_q);

	// next walk phase
	always_comb begin
		phase_d = eff_phase;
		case (eff_phase)
			stw_pkg::PH_HEADER: begin
				case (hpos)
					stw_pkg::HB_TYPE:      phase_d = is_eot ? stw_pkg::PH_IDLE : stw_pkg::PH_HEADER;
					stw_pkg::HB_LENGTH:    phase_d = is_malf ? stw_pkg::PH_IDLE : stw_pkg::PH_HEADER;
					stw_pkg::HB_HANDLE_LO: phase_d = stw_pkg::PH_HEADER;
					default: begin
						phase_d = (flen_q == stw_pkg::HEADER_BYTES) ? stw_pkg::PH_STRINGS
								: stw_pkg::PH_FORMATTED;
					end
				endcase
			end
			stw_pkg::PH_FORMATTED: phase_d = fmt_done ? stw_pkg::PH_STRINGS : stw_pkg::PH_FORMATTED;
			stw_pkg::PH_STRINGS: begin
				if (str_end) begin
					phase_d = too_big ? stw_pkg::PH_IDLE : stw_pkg::PH_HEADER;
				end
			end
			default: phase_d = stw_pkg::PH_IDLE;
		endcase
	end

	// datapath update and result
	always_comb begin
		pos_d    = eff_pos;
		flen_d   = flen_q;
		type_d   = type_q;
		handle_d = handle_q;
		pz_d     = pz_q;
		cnt_d    = eff_cnt;
		tlen_d   = eff_tlen;
		res_v    = 1'b0;
		res      = '0;
		case (eff_phase)
			stw_pkg::PH_HEADER: begin
				case (hpos)
					stw_pkg::HB_TYPE: begin
						type_d   = b;
						handle_d = 16'd0;
						flen_d   = 8'd0;
						if (is_eot) begin
							cnt_d  = sat_inc16(eff_cnt);
							tlen_d = sat_add32(eff_tlen, {24'd0, stw_pkg::HEADER_BYTES});
							res_v  = 1'b1;
							res    = '{struct_type: b, struct_handle: 16'd0,
								struct_length: {24'd0, stw_pkg::HEADER_BYTES},
								struct_count: cnt_d, table_length: tlen_d,
								walk_status: stw_pkg::ST_END};
						end else begin
							pos_d = 32'd1;
						end
					end
					stw_pkg::HB_LENGTH: begin
						flen_d = b;
						if (is_malf) begin
							res_v = 1'b1;
							res   = '{struct_type: type_q, struct_handle: 16'd0,
								struct_length: 32'd0, struct_count: eff_cnt,
								table_length: eff_tlen, walk_status: stw_pkg::ST_MALFORMED};
						end else begin
							pos_d = 32'd2;
						end
					end
					stw_pkg::HB_HANDLE_LO: begin
						handle_d = {8'd0, b};
						pos_d    = 32'd3;
					end
					default: begin
						handle_d = {b, handle_q[7:0]};
						pos_d    = {24'd0, stw_pkg::HEADER_BYTES};
						pz_d     = 1'b0;
					end
				endcase
			end
			stw_pkg::PH_FORMATTED: begin
				pos_d = pos_inc;
				if (fmt_done) begin
					pz_d = 1'b0;
				end
			end
			stw_pkg::PH_STRINGS: begin
				pos_d = pos_inc;
				if (str_end) begin
					tlen_d = len_sum;
					pos_d  = 32'd0;
					pz_d   = 1'b0;
					res_v  = 1'b1;
					if (!too_big) begin
						cnt_d = sat_inc16(cnt_q);
					end
					res = '{struct_type: type_q, struct_handle: handle_q,
						struct_length: pos_inc, struct_count: cnt_d,
						table_length: len_sum,
						walk_status: too_big ? stw_pkg::ST_TOO_BIG : stw_pkg::ST_DONE};
				end else begin
					pz_d = (b == 8'd0);
				end
			end
			default: begin
				pos_d = eff_pos;
			end
		endcase
	end

	// walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= stw_pkg::PH_IDLE;
			pos_q    <= 32'd0;
			flen_q   <= 8'd0;
			type_q   <= 8'd0;
			handle_q <= 16'd0;
			pz_q     <= 1'b0;
			cnt_q    <= 16'd0;
			tlen_q   <= 32'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			flen_q   <= flen_d;
			type_q   <= type_d;
			handle_q <= handle_d;
			pz_q     <= pz_d;
			cnt_q    <= cnt_d;
			tlen_q   <= tlen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= stw_pkg::MAX_TABLE_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// output register and skid: drain the skid first, park a result there on a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept && res_v;
			end
		end else if (accept && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept && res_v) begin
				out_q <= res;
			end
		end else if (accept && res_v) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a word while the output register is empty");

	a_stall_parks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_v && out_v_q && !out_ready) |=> skid_v_q)
		else $error("result lost during output stall");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == stw_pkg::PH_HEADER) |-> (pos_q < 32'd4))
		else $error("header byte position out of range");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_data.table_start) |=> (cnt_q >= $past(cnt_q)))
		else $error("structure count went backward without a start");

	a_end_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.walk_status == stw_pkg::ST_END) |-> (out_q.struct_length == 32'd4))
		else $error("end-of-table word with wrong length");
`endif

endmodule

`default_nettype wire

>>> test/tb_smbios_table_walker.sv
// Self-checking testbench for the byte-serial structure table walker.
`timescale 1ns / 100ps

module tb_smbios_table_walker;

	localparam int CYCLE_LIMIT   = 800_000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES   = 90;

	// Tracks the walk as the block should see it and queues the reports it must give.
	class walk_scoreboard;
		stw_pkg::stw_phase_t phase;
		logic [31:0]         pos;
		logic [7:0]          flen;
		logic [7:0]          cur_type;
		logic [15:0]         cur_handle;
		bit                  prev_zero;
		logic [15:0]         struct_total;
		logic [31:0]         length_total;
		logic [31:0]         max_len;
		stw_pkg::stw_out_t   pending_reports[$];
		int                  live_bytes;
		int                  report_total;
		int                  status_seen[4];
		int                  errors;

		function new();
			phase        = stw_pkg::PH_IDLE;
			pos          = '0;
			flen         = '0;
			cur_type     = '0;
			cur_handle   = '0;
			prev_zero    = 1'b0;
			struct_total = '0;
			length_total = '0;
			max_len      = stw_pkg::MAX_TABLE_RESET;
			live_bytes   = 0;
			report_total = 0;
			errors       = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function void bump_count();
			if (struct_total != 16'hFFFF)
				struct_total = struct_total + 16'd1;
		endfunction

		function void queue_report(logic [7:0] typ, logic [15:0] handle, logic [31:0] slen,
				stw_pkg::stw_status_t st);
			stw_pkg::stw_out_t r;
			r.struct_type   = typ;
			r.struct_handle = handle;
			r.struct_length = slen;
			r.struct_count  = struct_total;
			r.table_length  = length_total;
			r.walk_status   = st;
			pending_reports.push_back(r);
			status_seen[st]++;
			report_total++;
		endfunction

		function void note_byte(stw_pkg::stw_in_t w);
			logic [7:0] b;
			b = w.table_byte;
			if (w.table_start) begin
				struct_total = '0;
				length_total = '0;
				phase        = stw_pkg::PH_HEADER;
				pos          = '0;
			end
			if (phase != stw_pkg::PH_IDLE)
				live_bytes++;
			case (phase)
				stw_pkg::PH_HEADER: begin
					if (pos == 32'(stw_pkg::HB_TYPE)) begin
						cur_type   = b;
						cur_handle = '0;
						flen       = '0;
						if (b == stw_pkg::END_OF_TABLE_TYPE) begin
							bump_count();
							length_total = sat_add32(length_total,
								32'(stw_pkg::HEADER_BYTES));
							phase        = stw_pkg::PH_IDLE;
							queue_report(b, 16'h0000, 32'(stw_pkg::HEADER_BYTES),
								stw_pkg::ST_END);
						end else
							pos = 32'(stw_pkg::HB_LENGTH);
					end else if (pos == 32'(stw_pkg::HB_LENGTH)) begin
						flen = b;
						if (b < stw_pkg::HEADER_BYTES) begin
							phase = stw_pkg::PH_IDLE;
							queue_report(cur_type, 16'h0000, 32'h0, stw_pkg::ST_MALFORMED);
						end else
							pos = 32'(stw_pkg::HB_HANDLE_LO);
					end else if (pos == 32'(stw_pkg::HB_HANDLE_LO)) begin
						cur_handle = {8'h00, b};
						pos        = 32'(stw_pkg::HB_HANDLE_HI);
					end else begin
						cur_handle[15:8] = b;
						pos              = 32'(stw_pkg::HEADER_BYTES);
						prev_zero        = 1'b0;
						phase            = (flen == stw_pkg::HEADER_BYTES)
							? stw_pkg::PH_STRINGS : stw_pkg::PH_FORMATTED;
					end
				end
				stw_pkg::PH_FORMATTED: begin
					pos = pos + 32'd1;
					if (pos >= 32'(flen)) begin
						prev_zero = 1'b0;
						phase     = stw_pkg::PH_STRINGS;
					end
				end
				stw_pkg::PH_STRINGS: begin
					pos = sat_add32(pos, 32'd1);
					if (b == 8'h00 && prev_zero) begin
						length_total = sat_add32(length_total, pos);
						prev_zero    = 1'b0;
						// over the limit: report with the count held, then stop the walk
						if (length_total > max_len) begin
							phase = stw_pkg::PH_IDLE;
							queue_report(cur_type, cur_handle, pos, stw_pkg::ST_TOO_BIG);
						end else begin
							phase = stw_pkg::PH_HEADER;
							bump_count();
							queue_report(cur_type, cur_handle, pos, stw_pkg::ST_DONE);
						end
						pos = '0;
					end else
						prev_zero = (b == 8'h00);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_report(stw_pkg::stw_out_t got);
			stw_pkg::stw_out_t want;
			if (pending_reports.size() == 0) begin
				$error("report with nothing pending: type 0x%0h status %0d",
					got.struct_type, got.walk_status);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("struct_type", 32'(want.struct_type), 32'(got.struct_type));
			compare_field("struct_handle", 32'(want.struct_handle), 32'(got.struct_handle));
			compare_field("struct_length", want.struct_length, got.struct_length);
			compare_field("struct_count", 32'(want.struct_count), 32'(got.struct_count));
			compare_field("table_length", want.table_length, got.table_length);
			compare_field("walk_status", 32'(want.walk_status), 32'(got.walk_status));
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	stw_pkg::stw_in_t  in_data     = '0;
	logic              out_ready   = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [31:0]       cfg_wr_data = '0;
	logic              in_ready;
	logic              out_valid;
	stw_pkg::stw_out_t out_data;

	bit          calm        = 1'b0;
	bit          hold_req    = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned sent_bytes  = 0;
	walk_scoreboard sb;

	smbios_table_walker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Bytes are noted before reports are checked; a report never shares an edge with its byte.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_byte(in_data);
		if (out_valid && out_ready)
			sb.check_report(out_data);
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
				g = pick_gap();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	task automatic offer_byte(input logic [7:0] b, input bit s);
		int               g;
		stw_pkg::stw_in_t w;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		w.table_byte  = b;
		w.table_start = s;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		sent_bytes++;
	endtask

	task automatic offer_structure(input logic [7:0] typ, input logic [7:0] flen,
			input logic [15:0] handle, input bit opens, input int nstr);
		offer_byte(typ, opens);
		offer_byte(flen, 1'b0);
		if (flen < stw_pkg::HEADER_BYTES)
			return;
		offer_byte(handle[7:0], 1'b0);
		offer_byte(handle[15:8], 1'b0);
		repeat (int'(flen - stw_pkg::HEADER_BYTES)) offer_byte(8'($urandom), 1'b0);
		if (nstr == 0)
			offer_byte(8'h00, 1'b0);
		for (int k = 0; k < nstr; k++) begin
			repeat ($urandom_range(1, 8)) offer_byte(8'($urandom_range(1, 255)), 1'b0);
			offer_byte(8'h00, 1'b0);
		end
		offer_byte(8'h00, 1'b0);
	endtask

	// Drop valid, wait out every pending report, then let the pipeline settle.
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(input logic [31:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.max_len = v;
	endtask

	initial begin
		int unsigned target;
		int          nstruct;
		int          r;
		logic [31:0] v;
		logic [7:0]  typ;
		logic [7:0]  flen;

		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_max(stw_pkg::MAX_TABLE_RESET);

		// idle bytes, minimal and one-string structures, end marker, bad length, restart
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'h00, 1'b0);
		offer_structure(8'h00, 8'h04, 16'hFFFF, 1'b1, 0);
		offer_structure(8'hFF, 8'h05, 16'h0000, 1'b0, 1);
		offer_byte(stw_pkg::END_OF_TABLE_TYPE, 1'b0);
		offer_byte(stw_pkg::HEADER_BYTES, 1'b0);
		offer_byte(8'h00, 1'b0);
		offer_structure(8'h03, 8'h02, 16'h0000, 1'b1, 0);
		offer_byte(8'h55, 1'b0);
		offer_byte(8'h01, 1'b1);
		offer_byte(8'h08, 1'b0);
		offer_byte(8'h34, 1'b0);
		offer_byte(8'h12, 1'b0);
		offer_byte(8'hAA, 1'b0);
		offer_byte(stw_pkg::END_OF_TABLE_TYPE, 1'b1);
		drain_reports();

		// zero limit: first structure overflows, end marker skips the check
		write_max(32'h0);
		offer_structure(8'h10, 8'h04, 16'h1234, 1'b1, 0);
		offer_byte(8'h00, 1'b0);
		offer_byte(stw_pkg::END_OF_TABLE_TYPE, 1'b1);
		drain_reports();

		// limit hit exactly, then exceeded
		write_max(32'd12);
		offer_structure(8'h02, 8'h04, 16'h0101, 1'b1, 0);
		offer_structure(8'h03, 8'h04, 16'h0202, 1'b0, 0);
		offer_structure(8'h04, 8'h04, 16'h0303, 1'b0, 0);
		drain_reports();

		// back-pressure: receiver holds off while short structures keep coming
		write_max(stw_pkg::MAX_TABLE_RESET);
		calm     = 1'b1;
		hold_req = 1'b1;
		for (int k = 0; k < 21; k++)
			offer_structure(8'($urandom_range(0, 126)), stw_pkg::HEADER_BYTES,
				16'($urandom), k == 0, 0);
		drain_reports();
		calm = 1'b0;

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: v = stw_pkg::MAX_TABLE_RESET;
				1: v = $urandom;
				2: v = $urandom_range(30, 300);
				3: v = 32'h0;
				default: v = stw_pkg::MAX_TABLE_RESET;
			endcase
			calm = (ph == 4);
			write_max(v);
			target = sent_bytes + PHASE_BYTES;
			while (sent_bytes < target) begin
				r = $urandom_range(0, 99);
				if (r < 78) begin
					nstruct = $urandom_range(1, 6);
					for (int k = 0; k < nstruct; k++) begin
						typ = 8'($urandom);
						if (typ == stw_pkg::END_OF_TABLE_TYPE)
							typ = 8'h7E;
						if ($urandom_range(0, 24) == 0)
							flen = 8'($urandom_range(17, 255));
						else
							flen = 8'($urandom_range(4, 16));
						if ($urandom_range(0, 19) == 0)
							flen = 8'($urandom_range(0, 3));
						offer_structure(typ, flen, 16'($urandom), k == 0, $urandom_range(0, 3));
					end
					if ($urandom_range(0, 4) != 0) begin
						offer_byte(stw_pkg::END_OF_TABLE_TYPE, 1'b0);
						// trailing end-marker bytes fall on an idle walk
						if ($urandom_range(0, 1) == 1) begin
							offer_byte(stw_pkg::HEADER_BYTES, 1'b0);
							offer_byte(8'($urandom), 1'b0);
							offer_byte(8'($urandom), 1'b0);
							offer_byte(8'h00, 1'b0);
							offer_byte(8'h00, 1'b0);
						end
					end
				end else if (r < 92) begin
					repeat ($urandom_range(1, 12))
						offer_byte(8'($urandom), $urandom_range(0, 15) == 0);
				end else if ($urandom_range(0, 1) == 1)
					offer_byte(stw_pkg::END_OF_TABLE_TYPE, 1'b1);
				else
					offer_byte(8'($urandom), 1'b1);
			end
			drain_reports();
		end

		$display("Sent %0d bytes, %0d of them on a live walk, under several size limits.",
			sent_bytes, sb.live_bytes);
		$display("Reports: %0d done, %0d end of table, %0d over limit, %0d malformed.",
			sb.status_seen[stw_pkg::ST_DONE], sb.status_seen[stw_pkg::ST_END],
			sb.status_seen[stw_pkg::ST_TOO_BIG], sb.status_seen[stw_pkg::ST_MALFORMED]);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
